### hdl/marc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marc_pkg
// shared constants, types and run classification for the morse run classifier
// ----------------------------------------------------------------------------
package marc_pkg;

    localparam int WINDOW_SAMPLES = 10;
    localparam int COMPARE_OFFSET = 5;
    localparam int SAMPLE_BITS    = 16;
    localparam int RUN_COUNT_BITS = 16;
    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PHASE_BITS     = $clog2(WINDOW_SAMPLES);
    localparam int SYMBOL_BITS    = 3;
    localparam int OUT_DATA_BITS  = 8;
    localparam int SYMS_PER_ITEM  = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CMP_BITS       = (RUN_COUNT_BITS > CFG_BITS) ? RUN_COUNT_BITS : CFG_BITS;
    localparam bit CMP_IN_RANGE   = COMPARE_OFFSET < WINDOW_SAMPLES;

    localparam logic [CFG_BITS-1:0] DOT_RESET        = CFG_BITS'(882);
    localparam logic [CFG_BITS-1:0] DASH_RESET       = CFG_BITS'(2646);
    localparam logic [CFG_BITS-1:0] LETTER_GAP_RESET = CFG_BITS'(2646);
    localparam logic [CFG_BITS-1:0] WORD_GAP_RESET   = CFG_BITS'(7938);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DOT        = 2'd0,
        CFG_DASH       = 2'd1,
        CFG_LETTER_GAP = 2'd2,
        CFG_WORD_GAP   = 2'd3
    } cfg_index_t;

    typedef enum logic [SYMBOL_BITS-1:0] {
        SYM_DOT        = 3'd0,
        SYM_DASH       = 3'd1,
        SYM_LETTER_GAP = 3'd2,
        SYM_WORD_GAP   = 3'd3,
        SYM_END        = 3'd4
    } symbol_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] dot;
        logic [CFG_BITS-1:0] dash;
        logic [CFG_BITS-1:0] letter_gap;
        logic [CFG_BITS-1:0] word_gap;
    } cfg_regs_t;

    typedef struct packed {
        logic    hit;
        symbol_t sym;
    } sym_opt_t;

    // up to three symbols caused by one sample, in output order
    typedef struct packed {
        logic    [SYMS_PER_ITEM-1:0] valid;
        symbol_t [SYMS_PER_ITEM-1:0] sym;
    } bundle_t;

    // exact-length match of a finished run against the configured lengths
    function automatic sym_opt_t classify_run(
        input logic                      active,
        input logic                      tone,
        input logic [RUN_COUNT_BITS-1:0] count,
        input cfg_regs_t                 cfg
    );
        sym_opt_t             res;
        logic [CMP_BITS-1:0]  cnt;
        res.hit = 1'b0;
        res.sym = SYM_DOT;
        cnt     = CMP_BITS'(count);
        if (active) begin
            if (tone) begin
                if (cnt == CMP_BITS'(cfg.dot)) begin
                    res.hit = 1'b1;
                    res.sym = SYM_DOT;
                end
                else if (cnt == CMP_BITS'(cfg.dash)) begin
                    res.hit = 1'b1;
                    res.sym = SYM_DASH;
                end
            end
            else begin
                if (cnt == CMP_BITS'(cfg.word_gap)) begin
                    res.hit = 1'b1;
                    res.sym = SYM_WORD_GAP;
                end
                else if (cnt == CMP_BITS'(cfg.letter_gap)) begin
                    res.hit = 1'b1;
                    res.sym = SYM_LETTER_GAP;
                end
            end
        end
        return res;
    endfunction

endpackage

### hdl/marc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marc_front
// window classification, run counting and symbol bundling for each sample
// ----------------------------------------------------------------------------
module marc_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_accept,
    input  logic [marc_pkg::SAMPLE_BITS-1:0] in_sample,
    input  logic                           in_eos,
    input  logic                           cfg_write,
    input  logic [marc_pkg::CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [marc_pkg::CFG_BITS-1:0]  cfg_wdata,
    output logic                           push,
    output marc_pkg::bundle_t              push_data
);
    import marc_pkg::*;

    cfg_regs_t                 cfg_reg, cfg_next;
    logic [PHASE_BITS-1:0]     phase_reg, phase_next;
    logic [SAMPLE_BITS-1:0]    ref_reg, ref_next;
    logic                      decided_reg, decided_next;
    logic                      run_tone_reg, run_tone_next;
    logic                      run_active_reg, run_active_next;
    logic [RUN_COUNT_BITS-1:0] run_cnt_reg, run_cnt_next;

    logic                   is_first;
    logic                   is_cmp;
    logic [SAMPLE_BITS-1:0] ref_eff;
    logic                   decided_eff;
    logic                   do_add;
    logic                   tone;
    logic                   extend;
    sym_opt_t               ended;
    sym_opt_t               final_run;
    logic                   add_tone;
    logic                   add_active;
    logic [RUN_COUNT_BITS-1:0] add_cnt;
    cfg_index_t             cfg_sel;

    assign cfg_sel = cfg_index_t'(cfg_addr);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_sel)
                CFG_DOT:        cfg_next.dot        = cfg_wdata;
                CFG_DASH:       cfg_next.dash       = cfg_wdata;
                CFG_LETTER_GAP: cfg_next.letter_gap = cfg_wdata;
                CFG_WORD_GAP:   cfg_next.word_gap   = cfg_wdata;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        is_first    = (phase_reg == '0);
        is_cmp      = CMP_IN_RANGE && (phase_reg == PHASE_BITS'(COMPARE_OFFSET));
        ref_eff     = is_first ? in_sample : ref_reg;
        decided_eff = is_first ? 1'b0 : decided_reg;
        // an unclassified final window compares its reference against zero
        do_add      = is_cmp || (in_eos && !decided_eff);
        tone        = is_cmp ? (in_sample != ref_eff) : (ref_eff != '0);
        extend      = run_active_reg && (run_tone_reg == tone);
        ended       = classify_run(run_active_reg, run_tone_reg, run_cnt_reg, cfg_reg);

        add_tone   = run_tone_reg;
        add_active = run_active_reg;
        add_cnt    = run_cnt_reg;
        push_data  = '0;

        if (do_add) begin
            if (extend) begin
                add_cnt = (run_cnt_reg == '1) ? run_cnt_reg : run_cnt_reg + 1'b1;
            end
            else begin
                push_data.valid[0] = ended.hit;
                push_data.sym[0]   = ended.sym;
                add_tone   = tone;
                add_active = 1'b1;
                add_cnt    = RUN_COUNT_BITS'(1);
            end
        end

        final_run = classify_run(add_active, add_tone, add_cnt, cfg_reg);
        push_data.valid[1] = in_eos && final_run.hit;
        push_data.sym[1]   = final_run.sym;
        push_data.valid[2] = in_eos;
        push_data.sym[2]   = SYM_END;

        push = in_accept && (push_data.valid != '0);

        phase_next      = phase_reg;
        ref_next        = ref_reg;
        decided_next    = decided_reg;
        run_tone_next   = run_tone_reg;
        run_active_next = run_active_reg;
        run_cnt_next    = run_cnt_reg;
        if (in_accept) begin
            if (in_eos) begin
                phase_next      = '0;
                ref_next        = '0;
                decided_next    = 1'b0;
                run_tone_next   = 1'b0;
                run_active_next = 1'b0;
                run_cnt_next    = '0;
            end
            else begin
                phase_next      = (phase_reg == PHASE_BITS'(WINDOW_SAMPLES - 1))
                                  ? '0 : phase_reg + 1'b1;
                ref_next        = ref_eff;
                decided_next    = decided_eff || is_cmp;
                run_tone_next   = add_tone;
                run_active_next = add_active;
                run_cnt_next    = add_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.dot        <= DOT_RESET;
            cfg_reg.dash       <= DASH_RESET;
            cfg_reg.letter_gap <= LETTER_GAP_RESET;
            cfg_reg.word_gap   <= WORD_GAP_RESET;
            phase_reg          <= '0;
            ref_reg            <= '0;
            decided_reg        <= 1'b0;
            run_tone_reg       <= 1'b0;
            run_active_reg     <= 1'b0;
            run_cnt_reg        <= '0;
        end
        else begin
            cfg_reg        <= cfg_next;
            phase_reg      <= phase_next;
            ref_reg        <= ref_next;
            decided_reg    <= decided_next;
            run_tone_reg   <= run_tone_next;
            run_active_reg <= run_active_next;
            run_cnt_reg    <= run_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_eos |=> phase_reg == '0 && !run_active_reg && run_cnt_reg == '0)
        else $error("stream state not cleared after end of stream");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_active_reg |-> run_cnt_reg != '0)
        else $error("active run with zero length");
`endif

endmodule

### hdl/marc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marc_queue
// short bundle queue between the classifying front and the emitting back
// ----------------------------------------------------------------------------
module marc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  marc_pkg::bundle_t push_data,
    output logic              full,
    output logic              head_valid,
    output marc_pkg::bundle_t head_data,
    input  logic              pop
);
    import marc_pkg::*;

    bundle_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH) && !(push && full)
        && !(pop && !head_valid))
        else $error("bundle queue overflow or underflow");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("bundle queue count out of step with pushes");
`endif

endmodule

### hdl/marc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marc_back
// unpacks queued bundles into single symbol transactions on the output register
// ----------------------------------------------------------------------------
module marc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  marc_pkg::bundle_t head_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output marc_pkg::symbol_t out_symbol,
    output logic              out_last
);
    import marc_pkg::*;

    logic [SYMS_PER_ITEM-1:0] used_reg, used_next;
    logic                     valid_reg, valid_next;
    symbol_t                  sym_reg, sym_next;
    logic                     last_reg, last_next;

    logic [SYMS_PER_ITEM-1:0] remain;
    logic [SYMS_PER_ITEM-1:0] pick;
    logic [SYMS_PER_ITEM-1:0] after;
    symbol_t                  pick_sym;
    logic                     load;

    always_comb
    begin
        remain   = head_data.valid & ~used_reg;
        pick     = remain & (~remain + 1'b1);
        after    = remain & ~pick;
        pick_sym = head_data.sym[0];
        for (int i = SYMS_PER_ITEM - 1; i >= 0; i--) begin
            if (pick[i]) begin
                pick_sym = head_data.sym[i];
            end
        end

        load       = !valid_reg || out_ready;
        pop        = 1'b0;
        used_next  = used_reg;
        valid_next = valid_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                sym_next  = pick_sym;
                last_next = (after == '0);
                pop       = (after == '0);
                used_next = (after == '0) ? '0 : (used_reg | pick);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            used_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            used_reg  <= used_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        last_reg <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_symbol = sym_reg;
    assign out_last   = last_reg;

endmodule

### hdl/morse_audio_run_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_audio_run_classifier_top
// turns a pcm sample stream into morse dot, dash and gap symbols
// ----------------------------------------------------------------------------
// usage
//   s_* carries one sample per transaction: s_tdata is the signed sample,
//   s_tlast marks the final sample of a recording
//   m_* carries one symbol per transaction: m_tdata[2:0] is the symbol
//   (dot, dash, letter gap, word gap, end marker), m_tlast flags the last
//   symbol caused by one input sample
//   cfg_* writes the four run lengths; cfg_ready is always high and writes
//   are meant to happen only while the block is idle
// timing
//   one sample accepted per cycle while the queue has room; symbols pass
//   through the bundle queue and the output register to m_*; a sample
//   causing n symbols gives n transactions; the four-entry queue absorbs bursts
// reset
//   rst_n clears the stream state and loads the default run lengths
//   (882, 2646, 2646, 7938 windows); the queue and output are emptied
// back pressure
//   while m_tready is low the output holds; s_tready drops only once the
//   bundle queue is full
// ----------------------------------------------------------------------------
module morse_audio_run_classifier_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // slave stream: tdata = sample[15:0]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [marc_pkg::SAMPLE_BITS-1:0]     s_tdata,
    input  logic                                 s_tlast,
    // master stream: tdata = symbol[2:0], zero padding [7:3]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [marc_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                 m_tlast,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [marc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [marc_pkg::CFG_BITS-1:0]        cfg_data
);
    import marc_pkg::*;

    logic     in_accept;
    logic     push;
    bundle_t  push_data;
    logic     queue_full;
    logic     head_valid;
    bundle_t  head_data;
    logic     pop;
    symbol_t  out_symbol;

    // input taken whenever the queue has room for a bundle
    assign s_tready  = !queue_full;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // front: window compare, run counter and symbol bundle per sample
    marc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_sample (s_tdata),
        .in_eos    (s_tlast),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_addr  (cfg_index),
        .cfg_wdata (cfg_data),
        .push      (push),
        .push_data (push_data)
    );

    // queue: decouples front stalls from output back pressure
    marc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // back: one symbol per output transaction
    marc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_symbol (out_symbol),
        .out_last   (m_tlast)
    );

    // symbol in the low bits, rest zero
    assign m_tdata = OUT_DATA_BITS'(out_symbol);

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the morse audio run classifier
// ----------------------------------------------------------------------------
// pcm samples are streamed into the block mostly as whole windows of tone or
// silence, grouped into recordings that each close with an end-of-stream
// sample. a behavioral copy of the window, run and classification logic
// predicts every symbol, and each symbol transaction is checked against the
// oldest prediction. a few directed recordings come first. random recordings
// follow under three run-length settings, and a final tone run longer than
// both tone lengths must give nothing. both stream sides idle at random until
// the equal-gap recordings, which run at full rate like the final run.
// ----------------------------------------------------------------------------
module tb_top;

    import marc_pkg::*;

    localparam int STALL_LIMIT   = 5000;    // cycles with no transaction at all
    localparam int SETTLE_CYCLES = 8;       // output latency plus queue slack
    localparam logic [RUN_COUNT_BITS-1:0] RUN_LEN_MAX = '1;

    typedef struct packed {
        symbol_t sym;
        logic    last;
    } sym_expect_t;

    // dut connections, every input known from time zero
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [SAMPLE_BITS-1:0]    s_tdata   = '0;     // sample[15:0]
    logic                      s_tlast   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;            // symbol[2:0], zero pad [7:3]
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    cfg_index_t                cfg_index = CFG_DOT;
    logic [CFG_BITS-1:0]       cfg_data  = '0;

    // predictor copy of the stream state
    int unsigned               win_pos  = 0;
    logic [SAMPLE_BITS-1:0]    ref_smp  = '0;
    bit                        win_done = 1'b0;
    bit                        run_tone = 1'b0;
    bit                        run_live = 1'b0;
    logic [RUN_COUNT_BITS-1:0] run_len  = '0;

    // predictor copy of the run length registers
    logic [CFG_BITS-1:0]       len_dot        = DOT_RESET;
    logic [CFG_BITS-1:0]       len_dash       = DASH_RESET;
    logic [CFG_BITS-1:0]       len_letter_gap = LETTER_GAP_RESET;
    logic [CFG_BITS-1:0]       len_word_gap   = WORD_GAP_RESET;

    symbol_t                   new_syms[$];        // symbols of the current sample
    sym_expect_t               expected_syms[$];   // symbols still owed by the dut

    int                        src_idle_pct   = 0;
    int                        sink_stall_pct = 0;
    int                        items_sent     = 0;
    int                        syms_seen      = 0;
    int                        mismatches     = 0;

    morse_audio_run_classifier_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // symbol receiver, stalls at the current rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // exact length match of the run that just ended; word gap wins over
    // letter gap, dot over dash; a zero length never matches a live run
    task automatic close_run();
        if (run_live)
        begin
            if (run_tone)
            begin
                if (run_len == len_dot)
                    new_syms.push_back(SYM_DOT);
                else if (run_len == len_dash)
                    new_syms.push_back(SYM_DASH);
            end
            else
            begin
                if (run_len == len_word_gap)
                    new_syms.push_back(SYM_WORD_GAP);
                else if (run_len == len_letter_gap)
                    new_syms.push_back(SYM_LETTER_GAP);
            end
        end
    endtask

    // one classified window either extends the run or ends it
    task automatic add_window(input bit tone);
        win_done = 1'b1;
        if (run_live && run_tone == tone)
        begin
            // counter holds at its maximum
            if (run_len != RUN_LEN_MAX)
                run_len++;
        end
        else
        begin
            close_run();
            run_live = 1'b1;
            run_tone = tone;
            run_len  = RUN_COUNT_BITS'(1);
        end
    endtask

    // symbols caused by one accepted sample, queued in output order
    task automatic predict_symbols(input logic [SAMPLE_BITS-1:0] smp, input logic eos);
        sym_expect_t owed;
        new_syms.delete();
        if (win_pos == 0)
        begin
            ref_smp  = smp;
            win_done = 1'b0;
        end
        if (win_pos == COMPARE_OFFSET)
            add_window(smp != ref_smp);
        win_pos = (win_pos + 1 >= WINDOW_SAMPLES) ? 0 : win_pos + 1;
        if (eos)
        begin
            // an unfinished window compares its reference against zero
            if (!win_done)
                add_window(ref_smp != '0);
            close_run();
            new_syms.push_back(SYM_END);
            win_pos  = 0;
            ref_smp  = '0;
            win_done = 1'b0;
            run_tone = 1'b0;
            run_live = 1'b0;
            run_len  = '0;
        end
        foreach (new_syms[i])
        begin
            owed.sym  = new_syms[i];
            owed.last = (i == new_syms.size() - 1);
            expected_syms.push_back(owed);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic set_idle(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // one sample transaction; tvalid stays high for a back-to-back follower
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic eos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        predict_symbols(smp, eos);
    endtask

    // sender holds off until every owed symbol has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_syms.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DOT:        len_dot        = val;
            CFG_DASH:       len_dash       = val;
            CFG_LETTER_GAP: len_letter_gap = val;
            CFG_WORD_GAP:   len_word_gap   = val;
        endcase
    endtask

    // all four lengths in one burst, only once the block has gone quiet
    task automatic load_lengths(
        input logic [CFG_BITS-1:0] dot_len,
        input logic [CFG_BITS-1:0] dash_len,
        input logic [CFG_BITS-1:0] letter_len,
        input logic [CFG_BITS-1:0] word_len
    );
        wait_drained();
        cfg_valid <= 1'b1;
        put_reg(CFG_DOT, dot_len);
        put_reg(CFG_DASH, dash_len);
        put_reg(CFG_LETTER_GAP, letter_len);
        put_reg(CFG_WORD_GAP, word_len);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_ref();
        return ($urandom_range(3) == 0) ? '0 : SAMPLE_BITS'($urandom);
    endfunction

    // first count samples of a window that starts at offset 0
    task automatic send_window(
        input bit                     tone,
        input int                     count,
        input bit                     eos_last,
        input logic [SAMPLE_BITS-1:0] ref_val
    );
        logic [SAMPLE_BITS-1:0] smp;
        logic [SAMPLE_BITS-1:0] flip;
        int                     k;
        do
            flip = SAMPLE_BITS'($urandom);
        while (flip == '0);
        for (k = 0; k < count; k++)
        begin
            if (k == 0)
                smp = ref_val;
            else if (k == COMPARE_OFFSET)
                smp = tone ? (ref_val ^ flip) : ref_val;
            else
                smp = ($urandom_range(4) == 0) ? ref_val : SAMPLE_BITS'($urandom);
            send_sample(smp, eos_last && (k == count - 1));
        end
    endtask

    // run length in windows, often one that the current setting matches
    function automatic int pick_len(input bit tone);
        logic [CFG_BITS-1:0] first_len;
        logic [CFG_BITS-1:0] second_len;
        int                  n;
        first_len  = tone ? len_dot : len_word_gap;
        second_len = tone ? len_dash : len_letter_gap;
        n = int'($urandom_range(4, 1));
        if ($urandom_range(1) == 1 && first_len != 0 && first_len <= 4)
            n = int'(first_len);
        else if ($urandom_range(1) == 1 && second_len != 0 && second_len <= 4)
            n = int'(second_len);
        return n;
    endfunction

    // alternating runs of whole windows, then a final window of any fill
    // that carries end of stream
    task automatic send_recording();
        int n_runs;
        int r;
        bit tone;
        n_runs = int'($urandom_range(3));
        tone   = 1'($urandom_range(1));
        for (r = 0; r < n_runs; r++)
        begin
            repeat (pick_len(tone)) send_window(tone, WINDOW_SAMPLES, 1'b0, rand_ref());
            tone = !tone;
            if ($urandom_range(5) == 0)
                wait_drained();
        end
        send_window(1'($urandom_range(1)), int'($urandom_range(WINDOW_SAMPLES, 1)),
                    1'b1, rand_ref());
    endtask

    // unstructured samples, closed by end of stream
    task automatic send_noise();
        int n;
        int k;
        n = int'($urandom_range(25, 1));
        for (k = 0; k < n; k++)
            send_sample(SAMPLE_BITS'($urandom), k == n - 1);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset lengths are long, so a lone most-negative sample gives only the end
    task automatic test_reset_lengths();
        send_sample(16'h8000, 1'b1);
    endtask

    // two tone windows, the second cut short with a nonzero reference
    task automatic test_dash_on_open_window();
        load_lengths(16'd1, 16'd2, 16'd1, 16'd2);
        send_window(1'b1, WINDOW_SAMPLES, 1'b0, 16'h7FFF);
        send_sample(16'h0005, 1'b1);
    endtask

    // zero reference in the open window: dot, letter gap and end on one sample
    task automatic test_three_symbols();
        send_window(1'b1, WINDOW_SAMPLES, 1'b0, 16'h8000);
        send_sample(16'h0000, 1'b1);
    endtask

    task automatic run_recordings(input int min_items);
        int first_item;
        first_item = items_sent;
        while (items_sent - first_item < min_items)
        begin
            if ($urandom_range(99) < 85)
                send_recording();
            else
                send_noise();
        end
    endtask

    task automatic test_random_short_lengths();
        load_lengths(CFG_BITS'($urandom_range(3, 1)), CFG_BITS'($urandom_range(3, 1)),
                     CFG_BITS'($urandom_range(3, 1)), CFG_BITS'($urandom_range(3, 1)));
        run_recordings(55);
    endtask

    // zero dot length never matches, widest letter gap, shortest word gap
    task automatic test_random_extreme_lengths();
        load_lengths(16'd0, 16'd1, 16'hFFFF, 16'd1);
        run_recordings(55);
    endtask

    // equal gap lengths, word gap must win
    task automatic test_random_equal_gaps();
        load_lengths(16'd2, 16'd1, 16'd2, 16'd2);
        run_recordings(55);
    endtask

    // word gap from one silence window, then a tone run longer than
    // both tone lengths gives nothing before the end marker
    task automatic test_unmatched_long_run();
        load_lengths(16'd2, 16'd3, 16'd1, 16'd1);
        send_window(1'b0, WINDOW_SAMPLES, 1'b0, rand_ref());
        repeat (4) send_window(1'b1, WINDOW_SAMPLES, 1'b0, rand_ref());
        send_sample(16'h1234, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // symbol checker: every output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_symbols
        sym_expect_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            syms_seen++;
            if (expected_syms.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: symbol with none owed: tdata=%0h tlast=%0b",
                             $time, m_tdata, m_tlast);
            end
            else
            begin
                want = expected_syms.pop_front();
                if (m_tdata !== OUT_DATA_BITS'(want.sym) || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: symbol mismatch: expected %s tlast=%0b, got tdata=%0h tlast=%0b",
                                 $time, want.sym.name(), want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("morse_audio_run_classifier_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // sender idles lightly, receiver stalls often
        set_idle(20, 45);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_lengths();
        test_dash_on_open_window();
        test_three_symbols();
        test_random_short_lengths();

        // the other way round
        set_idle(45, 20);
        test_random_extreme_lengths();

        // full rate on both sides
        set_idle(0, 0);
        test_random_equal_gaps();
        test_unmatched_long_run();

        wait_drained();
        if (mismatches == 0 && expected_syms.size() == 0)
            $display("morse_audio_run_classifier_top test passed");
        else
            $display("morse_audio_run_classifier_top test failed");
        $finish;
    end

endmodule
